[hdl/tfdt_pkg.sv]
package tfdt_pkg;

    localparam int CoordW = 16;
    localparam int DepthW = 16;
    localparam int PixW   = 12;
    localparam int RgbW   = 24;
    localparam int CfgW   = 10;
    localparam int ZW     = 32;
    // numerators: 17b diff * 17b diff, summed -> 35 bits signed
    localparam int NumW   = 36;
    // weighted depth sum: 35b * 16b * 3 -> 53 bits
    localparam int SumW   = 54;
    // dividend den << 24
    localparam int DivW   = 60;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_idx_t;

    // result of the geometry stages, handed to the divider
    typedef struct packed {
        logic             keep;
        logic [SumW-1:0]  s;
        logic [NumW-1:0]  den;
        logic [11:0]      px;
        logic [11:0]      py;
        logic [RgbW-1:0]  rgb;
    } geo_t;

    typedef struct packed {
        logic [11:0]     px;
        logic [11:0]     py;
        logic [RgbW-1:0] rgb;
        logic [ZW-1:0]   z;
    } frag_t;

endpackage

[hdl/tfdt_ram.sv]
module tfdt_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/tfdt_geom.sv]
module tfdt_geom
    import tfdt_pkg::*;
#(
    parameter int MaxWidth  = 512,
    parameter int MaxHeight = 512
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [CoordW-1:0] x0, y0, x1, y1, x2, y2,
    input  logic [DepthW-1:0]        d0, d1, d2,
    input  logic signed [PixW-1:0]   px, py,
    input  logic [RgbW-1:0]          rgb,
    input  logic [CfgW-1:0]          fw, fh,
    output logic                     done,
    output geo_t                     geo
);
    // four stages after the input register: products, sums, sign fix, weighted sum
    logic [4:0] st_reg, st_next;
    logic signed [16:0] a_reg, b_reg, c_reg, e_reg, f_reg, g_reg, h_reg;
    logic signed [35:0] den_reg, n0_reg, n1_reg;
    logic signed [35:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [35:0] dn_reg, m0_reg, m1_reg, m2_reg;
    logic               keep_reg;
    logic               inb_reg;
    logic [DepthW-1:0]  d0_reg, d1_reg, d2_reg;
    logic [11:0]        px_reg, py_reg;
    logic [RgbW-1:0]    rgb_reg;
    logic signed [35:0] dn, m0, m1, m2;
    logic               neg;
    logic               inb;

    always_comb begin
        inb = !px[PixW-1] && !py[PixW-1]
              && ({1'b0, px} < {2'b0, fw}) && (32'(px) < MaxWidth)
              && ({1'b0, py} < {2'b0, fh}) && (32'(py) < MaxHeight);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
        if (start) begin
            a_reg   <= 17'(y1) - 17'(y2);
            b_reg   <= 17'(x0) - 17'(x2);
            c_reg   <= 17'(x2) - 17'(x1);
            e_reg   <= 17'(y0) - 17'(y2);
            f_reg   <= 17'(y2) - 17'(y0);
            g_reg   <= 17'({px, 4'b0}) - 17'(x2);
            h_reg   <= 17'({py, 4'b0}) - 17'(y2);
            inb_reg <= inb;
            d0_reg  <= d0;
            d1_reg  <= d1;
            d2_reg  <= d2;
            px_reg  <= px;
            py_reg  <= py;
            rgb_reg <= rgb;
        end
        if (st_reg[0]) begin
            p0_reg <= 36'(a_reg * b_reg);
            p1_reg <= 36'(c_reg * e_reg);
            p2_reg <= 36'(a_reg * g_reg);
            p3_reg <= 36'(c_reg * h_reg);
            p4_reg <= 36'(f_reg * g_reg);
            // x0-x2 = -(x2-x0): b*h
            p5_reg <= 36'(b_reg * h_reg);
        end
        if (st_reg[1]) begin
            den_reg <= p0_reg + p1_reg;
            n0_reg  <= p2_reg + p3_reg;
            n1_reg  <= p4_reg + p5_reg;
        end
        if (st_reg[2]) begin
            dn_reg   <= dn;
            m0_reg   <= m0;
            m1_reg   <= m1;
            m2_reg   <= m2;
            keep_reg <= inb_reg && (den_reg != '0) && !m0[35] && !m1[35] && !m2[35];
        end
        if (st_reg[3]) begin
            geo.keep <= keep_reg;
            geo.s    <= SumW'(m0_reg) * d0_reg + SumW'(m1_reg) * d1_reg
                        + SumW'(m2_reg) * d2_reg;
            geo.den  <= dn_reg;
            geo.px   <= px_reg;
            geo.py   <= py_reg;
            geo.rgb  <= rgb_reg;
        end
    end

    always_comb begin
        neg = den_reg[35];
        dn  = neg ? -den_reg : den_reg;
        m0  = neg ? -n0_reg : n0_reg;
        m1  = neg ? -n1_reg : n1_reg;
        m2  = dn - m0 - m1;
        st_next = {st_reg[3:0], start};
    end

    assign done = st_reg[4];
endmodule

[hdl/tfdt_div.sv]
module tfdt_div
    import tfdt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  geo_t          geo,
    output logic          done,
    output logic          keep,
    output frag_t         frag
);
    // restoring divider, one quotient bit per cycle
    localparam int CntW = $clog2(DivW + 1);

    logic              busy_reg, done_reg, keep_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [DivW-1:0]   quo_reg;
    logic [SumW:0]     rem_reg;
    logic [SumW-1:0]   div_reg;
    logic [SumW:0]     trial;
    logic [SumW:0]     sh;
    logic              zero_reg;
    logic [11:0]       px_reg, py_reg;
    logic [RgbW-1:0]   rgb_reg;

    always_comb begin
        sh    = {rem_reg[SumW-1:0], quo_reg[DivW-1]};
        trial = sh - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(DivW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            quo_reg  <= {geo.den[DivW-25:0], 24'b0};
            rem_reg  <= '0;
            div_reg  <= geo.s;
            zero_reg <= (geo.s == '0);
            keep_reg <= geo.keep;
            px_reg   <= geo.px;
            py_reg   <= geo.py;
            rgb_reg  <= geo.rgb;
        end else if (busy_reg) begin
            if (!trial[SumW]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DivW-2:0], 1'b1};
            end else begin
                rem_reg <= sh;
                quo_reg <= {quo_reg[DivW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        frag.px  = px_reg;
        frag.py  = py_reg;
        frag.rgb = rgb_reg;
        frag.z   = (zero_reg || (quo_reg[DivW-1:ZW] != '0)) ? '1 : quo_reg[ZW-1:0];
    end
    assign done = done_reg;
    assign keep = keep_reg;
endmodule

[hdl/triangle_fragment_depth_test.sv]
// channel | ports                                  | dir
// input   | s_valid s_ready s_v*_ s_pixel_* s_colour | in
// result  | m_valid m_ready m_out_x/y m_pixel_argb m_new_depth | out
// config  | cfg_we cfg_index cfg_data             | in
// One item is in flight at a time. m_valid rises after the input transfer has passed
// the geometry stages, the divider steps (one quotient bit a cycle), the depth read and
// the compare and write back. s_ready returns once the divider finishes for a pixel off
// the triangle or frame, after the compare when the depth test fails, and the cycle
// after the result transfer otherwise; a stalled result holds s_ready low.
// After reset a clearing pass writes zero to every depth entry, one per cycle
// (262144 entries at the default size), while s_ready stays low.
module triangle_fragment_depth_test
    import tfdt_pkg::*;
#(
    parameter int MaxWidth  = 512,
    parameter int MaxHeight = 512
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CfgW-1:0]          cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [CoordW-1:0] s_v0_x, s_v0_y,
    input  logic [DepthW-1:0]        s_v0_depth,
    input  logic signed [CoordW-1:0] s_v1_x, s_v1_y,
    input  logic [DepthW-1:0]        s_v1_depth,
    input  logic signed [CoordW-1:0] s_v2_x, s_v2_y,
    input  logic [DepthW-1:0]        s_v2_depth,
    input  logic signed [PixW-1:0]   s_pixel_x, s_pixel_y,
    input  logic [RgbW-1:0]          s_colour_rgb,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [8:0]               m_out_x,
    output logic [8:0]               m_out_y,
    output logic [31:0]              m_pixel_argb,
    output logic [ZW-1:0]            m_new_depth
);
    localparam int XW    = $clog2(MaxWidth);
    localparam int YW    = $clog2(MaxHeight);
    localparam int AW    = XW + YW;
    localparam int Depth = 1 << AW;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_GEO   = 6'b000100,
        S_DIV   = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [CfgW-1:0] fw_reg, fh_reg;
    logic [AW:0]     clr_reg;
    logic            geo_done, div_done, div_keep;
    geo_t            geo;
    frag_t           frag;
    frag_t           hold_reg;
    logic [AW-1:0]   addr;
    logic [ZW-1:0]   rdata;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [ZW-1:0]   wdata;
    logic            m_valid_reg;
    logic            s_fire;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign addr    = {frag.px[XW-1:0], frag.py[YW-1:0]};

    tfdt_geom #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_geom (
        .aclk, .aresetn, .start(s_fire),
        .x0(s_v0_x), .y0(s_v0_y), .x1(s_v1_x), .y1(s_v1_y), .x2(s_v2_x), .y2(s_v2_y),
        .d0(s_v0_depth), .d1(s_v1_depth), .d2(s_v2_depth),
        .px(s_pixel_x), .py(s_pixel_y), .rgb(s_colour_rgb),
        .fw(fw_reg), .fh(fh_reg), .done(geo_done), .geo(geo)
    );

    tfdt_div u_div (
        .aclk, .aresetn, .start(geo_done), .geo(geo),
        .done(div_done), .keep(div_keep), .frag(frag)
    );

    tfdt_ram #(.Width(ZW), .Depth(Depth)) u_zmem (
        .aclk, .we(we), .waddr(waddr), .wdata(wdata), .raddr(addr), .rdata(rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = addr;
        wdata = hold_reg.z;
        if (state_reg == S_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg[AW-1:0];
            wdata = '0;
        end else if (state_reg == S_READ && hold_reg.z >= rdata) begin
            we = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(Depth - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_fire) state_next = S_GEO;
            S_GEO:   if (geo_done) state_next = S_DIV;
            S_DIV: begin
                if (div_done) state_next = div_keep ? S_READ : S_IDLE;
            end
            S_READ:  state_next = (hold_reg.z >= rdata) ? S_OUT : S_IDLE;
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            fw_reg      <= CfgW'(480);
            fh_reg      <= CfgW'(480);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
                fw_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
                fh_reg <= cfg_data;
            end
            m_valid_reg <= (state_next == S_OUT);
        end
        if (div_done) begin
            hold_reg <= frag;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = hold_reg.px[8:0];
    assign m_out_y      = hold_reg.py[8:0];
    assign m_pixel_argb = {8'hFF, hold_reg.rgb};
    assign m_new_depth  = hold_reg.z;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_depth)) else $error("result dropped");
    a_no_write_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready) else $error("accept during clear");
endmodule
